>>> rtl/pare_pkg.sv
// ----------------------------------------------------------------------------
// pare_pkg
// shared widths, mode and config codes, word types and a saturating add for the particle age ring engine
// ----------------------------------------------------------------------------
package pare_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CAP_W     = SLOT_W + 1;
  localparam int AGE_W     = 32;
  localparam int ADDR_W    = SLOT_W + 1;
  localparam int EMIT_W    = 10;

  localparam logic [1:0] MODE_AGE  = 2'd0;
  localparam logic [1:0] MODE_EMIT = 2'd1;
  localparam logic [1:0] MODE_SWAP = 2'd2;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_LIFETIME = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [AGE_W-1:0] age_step;
    logic [AGE_W-1:0] carried_age;
    logic [10:0]      emit_count;
    logic [AGE_W-1:0] age_spread;
  } pare_in_t;

  typedef struct packed {
    logic [10:0]       live_count;
    logic [10:0]       dropped_count;
    logic [EMIT_W-1:0] emitted_count;
  } pare_out_t;

  // saturating unsigned add
  function automatic logic [AGE_W-1:0] sat_add(input logic [AGE_W-1:0] a,
                                               input logic [AGE_W-1:0] b);
    logic [AGE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AGE_W] ? {AGE_W{1'b1}} : s[AGE_W-1:0];
  endfunction

endpackage

>>> rtl/pare_div.sv
// ----------------------------------------------------------------------------
// pare_div
// restoring divider, one quotient bit per cycle, 32 by 10 bits
// ----------------------------------------------------------------------------
module pare_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pare_pkg::AGE_W-1:0]  dividend,
  input  logic [pare_pkg::EMIT_W-1:0] divisor,
  output logic                        done,
  output logic [pare_pkg::AGE_W-1:0]  quo,
  output logic [pare_pkg::EMIT_W-1:0] rem
);
  import pare_pkg::*;

  logic                  busy;
  logic [4:0]            cnt;
  logic [EMIT_W-1:0]     dsr;
  logic [EMIT_W:0]       trial;
  logic [EMIT_W:0]       diff;

  assign trial = {rem, quo[AGE_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 5'd0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= diff[EMIT_W-1:0];
          quo <= {quo[AGE_W-2:0], 1'b1};
        end else begin
          rem <= trial[EMIT_W-1:0];
          quo <= {quo[AGE_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/pare_store.sv
// ----------------------------------------------------------------------------
// pare_store
// age memory for both rings, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pare_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [pare_pkg::ADDR_W-1:0] waddr,
  input  logic [pare_pkg::AGE_W-1:0]  wdata,
  input  logic [pare_pkg::ADDR_W-1:0] raddr,
  output logic [pare_pkg::AGE_W-1:0]  rdata
);
  import pare_pkg::*;

  logic [AGE_W-1:0] mem [2*MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/particle_age_ring_engine.sv
// ----------------------------------------------------------------------------
// particle_age_ring_engine
// double-buffered ring of particle ages with aging, carry-over and emit
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_data) takes one command word: age, emit
//   or swap. out channel (out_valid/out_ready/out_data) returns one status
//   word per command: back ring live count, dropped and emitted counts.
//   cfg_we/cfg_index/cfg_data write capacity (index 0) or lifetime (index 1);
//   write only while the engine is idle.
// sequence
//   swap or unused mode: straight from idle to the finish step.
//   age: normalize both rings (clamp the live count, subtract capacity from
//   a stale start), age each live entry of the back ring, then copy entries
//   with the carried age. emit: normalize the back ring, divide the spread
//   by the emitted count, then write one age per emitted entry.
//   the single age memory port pair sets the one-slot-per-cycle walk.
// throughput
//   one command at a time; in_ready is high only when the sequencer idles.
//   a new command is taken while the last status word still waits.
// reset
//   both rings empty, ring 0 front, capacity 1024, lifetime all ones.
//   the age memory is not cleared.
// stall
//   a finished command holds in the last step until the out word is free.
// ----------------------------------------------------------------------------
module particle_age_ring_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pare_pkg::pare_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pare_pkg::pare_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import pare_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_AGE_SET, S_AGE, S_COPY_SET, S_COPY,
    S_EMIT_SET, S_EMIT_DIV, S_EMIT, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [CAP_W-1:0] ring_capacity;
  logic [AGE_W-1:0] lifetime;
  logic [CAP_W-1:0] cap;

  // ring pointers
  logic [1:0][SLOT_W-1:0] ring_start;
  logic [1:0][CAP_W-1:0]  ring_live;
  logic                   front_select;

  // per command registers
  pare_in_t          item;
  logic              bk;        // back ring
  logic              nr;        // ring being normalized
  logic [SLOT_W-1:0] idx;       // walk position
  logic [CAP_W-1:0]  n;         // entries left to age
  logic [CAP_W-1:0]  lv;        // running live count
  logic [CAP_W-1:0]  dropped;
  logic [EMIT_W-1:0] emitted;
  logic [SLOT_W-1:0] endp;

  // read in flight
  logic              pend;
  logic              pend_copy;
  logic [SLOT_W-1:0] pend_i;

  // emit spread stepping
  logic [AGE_W-1:0]  q;
  logic [EMIT_W-1:0] r;
  logic [EMIT_W-1:0] k;

  // memory and divider
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [AGE_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [AGE_W-1:0]  mem_rdata;
  logic              div_start;
  logic              div_done;
  logic [AGE_W-1:0]  div_quo;
  logic [EMIT_W-1:0] div_rem;

  // helpers
  logic [SLOT_W-1:0] idx_inc;
  logic [AGE_W-1:0]  aged;
  logic              too_old;
  logic [SLOT_W-1:0] st_n;
  logic [CAP_W-1:0]  lv_n;
  logic [CAP_W-1:0]  free_n;
  logic [CAP_W-1:0]  fm1;
  logic [EMIT_W-1:0] em;
  logic              emit_ok;
  logic [CAP_W:0]    sum_a;
  logic [CAP_W:0]    sum_b;
  logic [EMIT_W:0]   r_wrap;
  logic              pend_next;

  // capacity clamp to 2..MAX_SLOTS
  always_comb begin
    if (ring_capacity < CAP_W'(2)) cap = CAP_W'(2);
    else if (ring_capacity > CAP_W'(MAX_SLOTS)) cap = CAP_W'(MAX_SLOTS);
    else cap = ring_capacity;
  end

  assign idx_inc = ((CAP_W'(idx) + CAP_W'(1)) >= cap) ? '0 : idx + SLOT_W'(1);

  assign st_n = ring_start[nr];
  assign lv_n = ring_live[nr];

  // emit sizing
  assign free_n  = cap - ring_live[bk];
  assign fm1     = free_n - CAP_W'(1);
  assign emit_ok = (free_n > CAP_W'(1)) && (item.emit_count != '0);
  assign em      = (item.emit_count > fm1) ? fm1[EMIT_W-1:0] : item.emit_count[EMIT_W-1:0];

  // a read is issued this cycle during the age walk or the copy
  assign pend_next = ((state == S_AGE) && (n != '0)) ||
                     ((state == S_COPY) && (idx != endp) && (lv < cap));

  // shared adder for ring position sums
  always_comb begin
    unique case (state)
      S_COPY_SET: begin
        sum_a = {1'b0, CAP_W'(ring_start[bk])} + {1'b0, dropped};
        sum_b = {1'b0, CAP_W'(ring_start[~bk])} + {1'b0, ring_live[~bk]};
      end
      default: begin
        sum_a = {1'b0, CAP_W'(ring_start[bk])} + {1'b0, ring_live[bk]};
        sum_b = sum_a;
      end
    endcase
    if (sum_a >= {1'b0, cap}) sum_a = sum_a - {1'b0, cap};
    if (sum_b >= {1'b0, cap}) sum_b = sum_b - {1'b0, cap};
  end

  // write back of a read in flight, or an emitted age
  assign aged    = sat_add(mem_rdata, pend_copy ? item.carried_age : item.age_step);
  assign too_old = !pend_copy && (aged > lifetime);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bk, pend_i};
    mem_wdata = aged;
    if (pend) begin
      mem_we = !too_old;
    end else if (state == S_EMIT && k != '0) begin
      mem_we    = 1'b1;
      mem_waddr = {bk, idx};
      mem_wdata = q;
    end
  end

  assign mem_raddr = (state == S_COPY) ? {~bk, idx} : {bk, idx};
  assign div_start = (state == S_EMIT_SET) && emit_ok;
  assign r_wrap    = {1'b0, r} + {1'b0, item.emit_count[EMIT_W-1:0] & '0}
                     + {1'b0, emitted} - {1'b0, div_rem};

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ring_capacity <= CAP_W'(MAX_SLOTS);
      lifetime      <= {AGE_W{1'b1}};
      ring_start    <= '0;
      ring_live     <= '0;
      front_select  <= 1'b0;
      out_valid     <= 1'b0;
      pend          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAPACITY: ring_capacity <= cfg_data[CAP_W-1:0];
          CFG_LIFETIME: lifetime      <= cfg_data;
        endcase
      end
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;

      pend <= pend_next;
      if (pend && too_old) dropped <= dropped + CAP_W'(1);

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item    <= in_data;
            dropped <= '0;
            emitted <= '0;
            if (in_data.mode == MODE_SWAP) begin
              front_select <= ~front_select;
              bk           <= front_select;
            end else begin
              bk <= ~front_select;
            end
            nr <= ~front_select;
            if (in_data.mode == MODE_AGE || in_data.mode == MODE_EMIT) state <= S_NORM;
            else state <= S_FINISH;
          end
        end
        S_NORM: begin
          if (lv_n > cap) ring_live[nr] <= cap;
          if (CAP_W'(st_n) >= cap) begin
            ring_start[nr] <= st_n - cap[SLOT_W-1:0];
          end else if (item.mode == MODE_AGE && nr == bk) begin
            nr <= ~bk;
          end else if (item.mode == MODE_AGE) begin
            state <= S_AGE_SET;
          end else begin
            state <= S_EMIT_SET;
          end
        end
        S_AGE_SET: begin
          idx   <= ring_start[bk];
          n     <= ring_live[bk];
          lv    <= ring_live[bk];
          state <= S_AGE;
        end
        S_AGE: begin
          if (n != '0) begin
            pend_copy <= 1'b0;
            pend_i    <= idx;
            idx       <= idx_inc;
            n         <= n - CAP_W'(1);
          end else if (!pend) begin
            state <= S_COPY_SET;
          end
        end
        S_COPY_SET: begin
          ring_start[bk] <= sum_a[SLOT_W-1:0];
          lv             <= lv - dropped;
          endp           <= sum_b[SLOT_W-1:0];
          state          <= S_COPY;
        end
        S_COPY: begin
          if (idx != endp && lv < cap) begin
            pend_copy <= 1'b1;
            pend_i    <= idx;
            idx       <= idx_inc;
            lv        <= lv + CAP_W'(1);
          end else begin
            ring_live[bk] <= lv;
            state         <= S_FINISH;
          end
        end
        S_EMIT_SET: begin
          if (emit_ok) begin
            idx           <= sum_a[SLOT_W-1:0];
            ring_live[bk] <= ring_live[bk] + CAP_W'(em);
            emitted       <= em;
            state         <= S_EMIT_DIV;
          end else begin
            state <= S_FINISH;
          end
        end
        S_EMIT_DIV: begin
          if (div_done) begin
            q     <= item.age_spread;
            r     <= '0;
            k     <= emitted;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (k != '0) begin
            // step spread*k/n down to spread*(k-1)/n
            idx <= idx_inc;
            k   <= k - EMIT_W'(1);
            if (r < div_rem) begin
              q <= q - div_quo - AGE_W'(1);
              r <= r_wrap[EMIT_W-1:0];
            end else begin
              q <= q - div_quo;
              r <= r - div_rem;
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.live_count    <= ring_live[bk];
            out_data.dropped_count <= dropped;
            out_data.emitted_count <= emitted;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pare_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pare_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (item.age_spread),
    .divisor  (em),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

endmodule
